### rtl/maa_pkg.sv
// ----------------------------------------------------------------------------
// maa_pkg
// Shared types and constants for the motion activity accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package maa_pkg;

  // field widths
  localparam int unsigned AccelW  = 8;
  localparam int unsigned ThreshW = 8;
  localparam int unsigned LevelW  = 10;
  localparam int unsigned ChangeW = 10;
  localparam int unsigned TotalW  = 32;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  // register map
  localparam logic [AddrW-1:0] AddrThreshold = 3'd0;
  localparam logic [AddrW-1:0] AddrLevel     = 3'd4;

  // reset values
  localparam logic [ThreshW-1:0] ThresholdReset = 8'd2;
  localparam logic [LevelW-1:0]  LevelReset     = 10'h024;

  // item codes
  localparam logic OpSample = 1'b0;
  localparam logic OpLoad   = 1'b1;

  typedef logic signed [AccelW-1:0] accel_t;
  typedef logic [TotalW-1:0]        total_t;

  // registered input word
  typedef struct packed {
    logic   op;
    accel_t accel_x;
    accel_t accel_y;
    accel_t accel_z;
    logic   sensor_is_slow;
    total_t load_value;
  } maa_item_t;

  // result word
  typedef struct packed {
    logic               sample_used;
    logic [ChangeW-1:0] sample_change;
    total_t             activity_total;
    logic               request_fast;
  } maa_result_t;

endpackage

`default_nettype wire

### rtl/maa_axis.sv
// ----------------------------------------------------------------------------
// maa_axis
// One axis: halving smoother and thresholded absolute change.
// ----------------------------------------------------------------------------
`default_nettype none

module maa_axis (
  input  wire  maa_pkg::accel_t              raw,
  input  wire  maa_pkg::accel_t              history,
  input  wire  maa_pkg::accel_t              previous,
  input  wire  logic                         ref_pending,
  input  wire  logic [maa_pkg::ThreshW-1:0]  threshold,
  output maa_pkg::accel_t                    smoothed,
  output logic [maa_pkg::AccelW-1:0]         change
);
  import maa_pkg::*;

  logic signed [AccelW:0] pair_sum;
  logic signed [AccelW:0] sum_adj;
  accel_t                 base;
  logic signed [AccelW:0] diff;
  logic [AccelW:0]        mag;

  // (x + y) / 2 truncated toward zero: bias negative sums by one, then shift
  assign pair_sum = {raw[AccelW-1], raw} + {history[AccelW-1], history};
  assign sum_adj  = pair_sum + {{AccelW{1'b0}}, pair_sum[AccelW]};
  assign smoothed = sum_adj[AccelW:1];

  // first smoothed sample is its own reference
  assign base = ref_pending ? smoothed : previous;
  assign diff = {smoothed[AccelW-1], smoothed} - {base[AccelW-1], base};
  assign mag  = diff[AccelW] ? (~diff + 1'b1) : diff;

  // small changes count as zero
  assign change = (mag[AccelW-1:0] >= threshold) ? mag[AccelW-1:0] : '0;

endmodule

`default_nettype wire

### rtl/motion_activity_accumulator_unit.sv
// A word accepted into the input register moves to the result register, or to the skid
// stage while the output stalls. Throughput: one word per cycle while out_stall stays low; the
// input register feeds a single layer of filter, change and total logic into the result register.
// Reset (rst, synchronous): filter unprimed, history and total zero,
// change_threshold 2, fast_switch_level 36, no words in flight.
// ----------------------------------------------------------------------------
// motion_activity_accumulator_unit
// Smooths three-axis samples and accumulates thresholded motion activity.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_activity_accumulator_unit (
  input  wire  logic                            clk,
  input  wire  logic                            rst,
  // configuration port
  input  wire  logic                            psel,
  input  wire  logic                            penable,
  input  wire  logic                            pwrite,
  input  wire  logic [maa_pkg::AddrW-1:0]       paddr,
  input  wire  logic [maa_pkg::DataW-1:0]       pwdata,
  output logic [maa_pkg::DataW-1:0]             prdata,
  output logic                                  pready,
  // input channel
  input  wire  logic                            in_valid,
  output logic                                  in_stall,
  input  wire  logic                            op,
  input  wire  maa_pkg::accel_t                 accel_x,
  input  wire  maa_pkg::accel_t                 accel_y,
  input  wire  maa_pkg::accel_t                 accel_z,
  input  wire  logic                            sensor_is_slow,
  input  wire  maa_pkg::total_t                 load_value,
  // output channel
  output logic                                  out_valid,
  input  wire  logic                            out_stall,
  output logic                                  sample_used,
  output logic [maa_pkg::ChangeW-1:0]           sample_change,
  output maa_pkg::total_t                       activity_total,
  output logic                                  request_fast
);
  import maa_pkg::*;

  typedef enum logic [1:0] {
    PH_UNPRIMED = 2'd0,
    PH_PRIMED   = 2'd1,
    PH_REF_SET  = 2'd2
  } phase_t;

  // configuration
  logic [ThreshW-1:0] change_threshold;
  logic [LevelW-1:0]  fast_switch_level;
  logic               cfg_write;

  // filter and total state
  phase_t  filter_phase;
  accel_t  history   [3];
  accel_t  previous  [3];
  total_t  activity_sum;

  // pipeline registers
  maa_item_t   s1_item;
  logic        s1_valid;
  maa_result_t out_word;
  maa_result_t skid_word;
  logic        skid_full;

  logic        in_accept;
  logic        s1_move;
  logic        out_take;

  accel_t           raw       [3];
  accel_t           smoothed  [3];
  logic [AccelW-1:0] axis_change [3];
  logic [ChangeW-1:0] change_sum;
  total_t           sum_next;
  maa_result_t      result;
  logic             ref_pending;

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == AddrLevel[2]) begin
      prdata = {{(DataW-LevelW){1'b0}}, fast_switch_level};
    end else begin
      prdata = {{(DataW-ThreshW){1'b0}}, change_threshold};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      change_threshold  <= ThresholdReset;
      fast_switch_level <= LevelReset;
    end else if (cfg_write) begin
      if (paddr[2] == AddrLevel[2]) begin
        fast_switch_level <= pwdata[LevelW-1:0];
      end else begin
        change_threshold <= pwdata[ThreshW-1:0];
      end
    end
  end

  // handshakes
  assign in_stall  = skid_full & s1_valid;
  assign in_accept = in_valid & ~in_stall;
  assign s1_move   = s1_valid & ~skid_full;
  assign out_take  = out_valid & ~out_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept | (s1_valid & ~s1_move);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.op             <= op;
      s1_item.accel_x        <= accel_x;
      s1_item.accel_y        <= accel_y;
      s1_item.accel_z        <= accel_z;
      s1_item.sensor_is_slow <= sensor_is_slow;
      s1_item.load_value     <= load_value;
    end
  end

  // per-axis filter and change
  assign raw[0]      = s1_item.accel_x;
  assign raw[1]      = s1_item.accel_y;
  assign raw[2]      = s1_item.accel_z;
  assign ref_pending = (filter_phase == PH_PRIMED);

  for (genvar g = 0; g < 3; g++) begin : g_axis
    maa_axis u_axis (
      .raw         (raw[g]),
      .history     (history[g]),
      .previous    (previous[g]),
      .ref_pending (ref_pending),
      .threshold   (change_threshold),
      .smoothed    (smoothed[g]),
      .change      (axis_change[g])
    );
  end

  // sum of axis changes and running total
  assign change_sum = {2'b00, axis_change[0]} + {2'b00, axis_change[1]}
                    + {2'b00, axis_change[2]};
  assign sum_next   = activity_sum + {{(TotalW-ChangeW){1'b0}}, change_sum};

  // result word
  always_comb begin
    result.sample_used    = 1'b0;
    result.sample_change  = '0;
    result.activity_total = activity_sum;
    result.request_fast   = 1'b0;
    if (s1_item.op == OpLoad) begin
      result.activity_total = s1_item.load_value;
    end else if (filter_phase != PH_UNPRIMED) begin
      result.sample_used    = 1'b1;
      result.sample_change  = change_sum;
      result.activity_total = sum_next;
      result.request_fast   = (change_sum > fast_switch_level) & s1_item.sensor_is_slow;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_phase <= PH_UNPRIMED;
      activity_sum <= '0;
      for (int i = 0; i < 3; i++) begin
        history[i]  <= '0;
        previous[i] <= '0;
      end
    end else if (s1_move) begin
      activity_sum <= result.activity_total;
      if (s1_item.op == OpSample) begin
        if (filter_phase == PH_UNPRIMED) begin
          filter_phase <= PH_PRIMED;
          for (int i = 0; i < 3; i++) begin
            history[i] <= raw[i];
          end
        end else begin
          filter_phase <= PH_REF_SET;
          for (int i = 0; i < 3; i++) begin
            history[i]  <= smoothed[i];
            previous[i] <= smoothed[i];
          end
        end
      end
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_take) begin
        skid_full <= 1'b0;
      end
    end else if (s1_move) begin
      if (out_valid & ~out_take) begin
        skid_full <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_take) begin
        out_word <= skid_word;
      end
    end else if (s1_move) begin
      if (out_valid & ~out_take) begin
        skid_word <= result;
      end else begin
        out_word <= result;
      end
    end
  end

  assign sample_used    = out_word.sample_used;
  assign sample_change  = out_word.sample_change;
  assign activity_total = out_word.activity_total;
  assign request_fast   = out_word.request_fast;

endmodule

`default_nettype wire

### dv/motion_activity_accumulator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motion_activity_accumulator_unit_tb
// Feeds sample and load words through the accumulator under several register
// settings and idling patterns. Each accepted word is run through a local
// predictor of the filter, change and total logic, and every result word is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module motion_activity_accumulator_unit_tb;
  import maa_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 8;

  typedef enum logic [1:0] {
    PhaseUnprimed,
    PhasePrimed,
    PhaseReference
  } filt_phase_t;

  // clock, reset and block inputs, all known from time zero
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  maa_item_t         in_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              sample_used;
  logic [ChangeW-1:0] sample_change;
  total_t            activity_total;
  logic              request_fast;

  // stimulus and checking state
  maa_item_t   pending_words[$];
  maa_result_t awaited_results[$];
  logic        in_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          mismatches = 0;
  int          cycles = 0;
  accel_t      last_raw[3] = '{default: '0};

  // predictor state and register copies
  accel_t               hist_acc[3];
  accel_t               prev_smooth[3];
  filt_phase_t          filt_phase = PhaseUnprimed;
  total_t               total_acc = '0;
  logic [ThreshW-1:0]   thr_cfg = ThresholdReset;
  logic [LevelW-1:0]    lvl_cfg = LevelReset;

  motion_activity_accumulator_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (in_word.op),
    .accel_x        (in_word.accel_x),
    .accel_y        (in_word.accel_y),
    .accel_z        (in_word.accel_z),
    .sensor_is_slow (in_word.sensor_is_slow),
    .load_value     (in_word.load_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sample_used    (sample_used),
    .sample_change  (sample_change),
    .activity_total (activity_total),
    .request_fast   (request_fast)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // smoothing, thresholded change and running total for one accepted word
  function automatic maa_result_t predict_activity(input maa_item_t w);
    maa_result_t        r;
    accel_t             raw[3];
    accel_t             sm[3];
    int                 s;
    int                 d;
    int                 i;
    logic [ChangeW-1:0] change;
    r = '0;
    change = '0;
    if (w.op == OpLoad) begin
      total_acc = w.load_value;
      r.activity_total = total_acc;
      return r;
    end
    raw[0] = w.accel_x;
    raw[1] = w.accel_y;
    raw[2] = w.accel_z;
    // first sample only primes the filter
    if (filt_phase == PhaseUnprimed) begin
      hist_acc = raw;
      filt_phase = PhasePrimed;
      r.activity_total = total_acc;
      return r;
    end
    // halve the sum, truncating toward zero
    for (i = 0; i < 3; i++) begin
      s = int'(raw[i]) + int'(hist_acc[i]);
      sm[i] = (s < 0) ? accel_t'(-((-s) / 2)) : accel_t'(s / 2);
      hist_acc[i] = sm[i];
    end
    // first smoothed sample becomes the reference
    if (filt_phase == PhasePrimed) begin
      prev_smooth = sm;
      filt_phase = PhaseReference;
    end
    // full-width absolute change per axis, gated by the threshold
    for (i = 0; i < 3; i++) begin
      d = int'(sm[i]) - int'(prev_smooth[i]);
      if (d < 0) d = -d;
      if (d >= int'(thr_cfg)) change += d[ChangeW-1:0];
      prev_smooth[i] = sm[i];
    end
    total_acc += change;
    r.sample_used = 1'b1;
    r.sample_change = change;
    r.activity_total = total_acc;
    r.request_fast = (change > lvl_cfg) && w.sensor_is_slow;
    return r;
  endfunction

  // input driver: new word once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_word <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall, with a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // input acceptance and prediction
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      awaited_results.push_back(predict_activity(in_word));
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    maa_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected word: used %0d change %0d total %h fast %0d", $time,
                 sample_used, sample_change, activity_total, request_fast);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (sample_used !== want.sample_used) begin
          $display("%0t: sample_used expected %0d actual %0d", $time,
                   want.sample_used, sample_used);
          mismatches++;
        end
        if (sample_change !== want.sample_change) begin
          $display("%0t: sample_change expected %0d actual %0d", $time,
                   want.sample_change, sample_change);
          mismatches++;
        end
        if (activity_total !== want.activity_total) begin
          $display("%0t: activity_total expected %h actual %h", $time,
                   want.activity_total, activity_total);
          mismatches++;
        end
        if (request_fast !== want.request_fast) begin
          $display("%0t: request_fast expected %0d actual %0d", $time,
                   want.request_fast, request_fast);
          mismatches++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // register write, setup then access
  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrThreshold) thr_cfg = data[ThreshW-1:0];
    else if (addr == AddrLevel) lvl_cfg = data[LevelW-1:0];
  endtask

  task automatic add_item(input logic o, input accel_t x, input accel_t y, input accel_t z,
                          input logic slow, input total_t load);
    maa_item_t w;
    w.op = o;
    w.accel_x = x;
    w.accel_y = y;
    w.accel_z = z;
    w.sensor_is_slow = slow;
    w.load_value = load;
    pending_words.push_back(w);
  endtask

  // random word: mostly samples that wander near the last one
  task automatic push_random();
    maa_item_t w;
    accel_t    raw[3];
    int        i;
    for (i = 0; i < 3; i++) begin
      case ($urandom_range(3))
        0: raw[i] = accel_t'($urandom);
        1: raw[i] = $urandom_range(1) ? accel_t'(127) : accel_t'(-128);
        default: raw[i] = last_raw[i] + accel_t'($urandom_range(8)) - accel_t'(4);
      endcase
    end
    w.op = ($urandom_range(99) < 6) ? OpLoad : OpSample;
    w.accel_x = raw[0];
    w.accel_y = raw[1];
    w.accel_z = raw[2];
    w.sensor_is_slow = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: w.load_value = 32'hFFFF_FFFF - $urandom_range(1000);
      1: w.load_value = $urandom_range(1000);
      default: w.load_value = $urandom;
    endcase
    if (w.op == OpSample) last_raw = raw;
    pending_words.push_back(w);
  endtask

  // one phase of random words, then drain
  task automatic run_phase(input int n, input int send_pct, input int recv_pct,
                           input bit hold_off);
    int k;
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (k = 0; k < n; k++) push_random();
    if (hold_off) hold_requests++;
    while (pending_words.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: priming, reference, extremes, wrap, load and threshold edge
    add_item(OpSample, -128, 127, 0, 1'b1, 32'd0);
    add_item(OpSample, 127, -128, 1, 1'b1, 32'd0);
    add_item(OpSample, -128, -128, -128, 1'b1, 32'd0);
    add_item(OpSample, 127, 127, 127, 1'b0, 32'd0);
    add_item(OpLoad, 127, -128, 127, 1'b1, 32'hFFFF_FFF0);
    add_item(OpSample, 127, 127, 127, 1'b1, 32'd0);
    repeat (9) add_item(OpSample, -128, -128, -128, 1'b1, 32'hFFFF_FFFF);
    add_item(OpSample, -125, -124, -126, 1'b1, 32'd0);
    add_item(OpLoad, 0, 0, 0, 1'b1, 32'd0);
    add_item(OpSample, 0, 0, 0, 1'b1, 32'd0);
    add_item(OpSample, 127, -128, 0, 1'b0, 32'hFFFF_FFFF);
    add_item(OpLoad, -128, 127, -128, 1'b0, 32'hFFFF_FFFF);
    add_item(OpSample, -128, 127, 127, 1'b1, 32'd0);
    run_phase(150, 0, 0, 1'b0);

    // every change counts, any nonzero change from a slow sensor requests fast rate
    write_reg(AddrThreshold, 32'd0);
    write_reg(AddrLevel, 32'd0);
    run_phase(200, 71, 0, 1'b0);

    // top of the threshold range, level at the largest possible change sum
    write_reg(AddrThreshold, 32'd255);
    write_reg(AddrLevel, 32'd765);
    run_phase(150, 0, 71, 1'b0);

    // low threshold, moderate level, with a long output hold-off
    write_reg(AddrThreshold, $urandom_range(12));
    write_reg(AddrLevel, $urandom_range(120));
    run_phase(250, 15, 15, 1'b1);

    // random settings, sender never idle while the output holds off
    write_reg(AddrThreshold, $urandom_range(255));
    write_reg(AddrLevel, $urandom_range(765));
    run_phase(250, 0, 0, 1'b1);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
